### rtl/sgs_pkg.sv
package sgs_pkg;

  // Fixed field widths of the sample stream.
  localparam int SGS_SAMPLE_BITS = 16;
  localparam int SGS_MAX_WINDOW  = 15;

  // Configuration register file.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 1'b1;
  localparam logic [CFG_W-1:0]     WINDOW_RST = 4'd5;
  localparam logic [CFG_W-1:0]     ORDER_RST  = 4'd2;

  // Largest window the register can express, and the tail it can leave behind.
  localparam int VIEW_D = 2**CFG_W - 1;
  localparam int TAIL_D = VIEW_D / 2 + 1;
  localparam int IDX_W  = $clog2(TAIL_D);
  localparam int CNT_W  = $clog2(TAIL_D + 1);

  // Job queue between the front and the result sequencer.
  localparam int QDEPTH = 8;

  // Arithmetic.
  localparam int FRAC_BITS = 18;
  localparam int RCP_W     = 17;
  localparam int COEF_W    = 9;
  localparam int SUM_W     = SGS_SAMPLE_BITS + 10;

  // Smoothing modes.
  localparam logic [1:0] MODE_MA   = 2'd0;
  localparam logic [1:0] MODE_SG52 = 2'd1;
  localparam logic [1:0] MODE_SG72 = 2'd2;
  localparam logic [1:0] MODE_SG73 = 2'd3;

  typedef logic signed [SGS_SAMPLE_BITS-1:0] smp_t;
  typedef smp_t [TAIL_D-1:0] tail_t;

  typedef struct packed {
    smp_t sample;
    logic last_sample;
  } in_beat_t;

  typedef struct packed {
    smp_t smoothed;
    logic last_result;
    logic record_too_short;
    logic config_error;
  } out_beat_t;

  // What the result sequencer must do for one accepted sample.
  typedef struct packed {
    logic             err;
    logic             last;
    logic             short_rec;
    logic             has_smooth;
    logic [IDX_W-1:0] half;
    logic [IDX_W-1:0] p0;
    logic [CNT_W-1:0] cnt;
  } job_t;

  // What the arithmetic pipeline needs for one job.
  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] win_len;
    logic [RCP_W-1:0] rcp;
  } ctl_t;

  typedef struct packed {
    job_t  job;
    tail_t tail;
    smp_t  smooth;
  } qent_t;

  // Q0.18 reciprocal of the denominator, rounded to nearest.
  function automatic logic [RCP_W-1:0] sgs_recip(input logic [1:0] mode,
                                                 input logic [CFG_W-1:0] wl);
    logic [RCP_W-1:0] r;
    r = '0;
    case (mode)
      MODE_SG52: r = RCP_W'(7490);
      MODE_SG72: r = RCP_W'(12483);
      MODE_SG73: r = RCP_W'(1135);
      default: begin
        case (wl)
          4'd3:    r = RCP_W'(87381);
          4'd5:    r = RCP_W'(52429);
          4'd7:    r = RCP_W'(37449);
          4'd9:    r = RCP_W'(29127);
          4'd11:   r = RCP_W'(23831);
          4'd13:   r = RCP_W'(20165);
          4'd15:   r = RCP_W'(17476);
          default: r = '0;
        endcase
      end
    endcase
    return r;
  endfunction

  // Integer coefficient k of a Savitzky-Golay mode, center first.
  function automatic logic signed [COEF_W-1:0] sgs_coef(input logic [1:0] mode,
                                                        input logic [1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (mode)
      MODE_SG52: begin
        case (k)
          2'd0:    c = 9'sd17;
          2'd1:    c = 9'sd12;
          2'd2:    c = -9'sd3;
          default: c = '0;
        endcase
      end
      MODE_SG72: begin
        case (k)
          2'd0:    c = 9'sd7;
          2'd1:    c = 9'sd6;
          2'd2:    c = 9'sd3;
          default: c = -9'sd2;
        endcase
      end
      MODE_SG73: begin
        case (k)
          2'd0:    c = 9'sd131;
          2'd1:    c = 9'sd75;
          2'd2:    c = -9'sd30;
          default: c = 9'sd5;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/sgs_front.sv
module sgs_front
  import sgs_pkg::*;
#(
  parameter int MAX_WINDOW = SGS_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pop,
  output logic                 job_vld,
  output job_t                 job,
  output ctl_t                 ctl,
  output smp_t [VIEW_D-1:0]    win
);

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int USED_W = $clog2(QDEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_WINDOW);

  smp_t              line_r [MAX_WINDOW];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CFG_W-1:0]  wl_r, po_r;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              job_vld_r;
  job_t              job_r, job_nxt;
  ctl_t              ctl_r, ctl_nxt;

  logic              accept, launch, cfg_ok;
  logic [FILL_W-1:0] n;
  logic [CMP_W-1:0]  n_c, wl_c;
  logic [IDX_W-1:0]  half;
  logic [CNT_W-1:0]  half1, m;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (used_r >= USED_W'(QDEPTH));
  assign cfg_ready = 1'b1;

  always_comb begin
    n     = (fill_r == FILL_MAX) ? fill_r : FILL_W'(fill_r + 1'b1);
    n_c   = CMP_W'(n);
    wl_c  = CMP_W'(wl_r);
    half  = IDX_W'(wl_r >> 1);
    half1 = CNT_W'(half) + CNT_W'(1);
    m     = (n_c < CMP_W'(half1)) ? CNT_W'(n_c) : half1;

    cfg_ok = (wl_r >= CFG_W'(3)) && wl_r[0] && (wl_c <= CMP_W'(MAX_WINDOW)) &&
             (po_r != '0) && (po_r < wl_r);

    fill_nxt = in_beat.last_sample ? '0 : n;

    job_nxt            = '0;
    job_nxt.err        = !cfg_ok;
    job_nxt.last       = in_beat.last_sample;
    job_nxt.half       = half;
    job_nxt.has_smooth = (n_c >= wl_c);
    job_nxt.short_rec  = cfg_ok && in_beat.last_sample && (n_c < wl_c);
    if (!cfg_ok) begin
      job_nxt.cnt = CNT_W'(1);
      job_nxt.p0  = '0;
    end else if (!in_beat.last_sample) begin
      job_nxt.cnt = CNT_W'(1);
      job_nxt.p0  = half;
    end else begin
      job_nxt.cnt = m;
      job_nxt.p0  = IDX_W'(m - CNT_W'(1));
    end
    launch = accept && (!cfg_ok || in_beat.last_sample || (n_c > CMP_W'(half)));

    ctl_nxt.win_len = wl_r;
    if (wl_r == CFG_W'(5) && po_r == CFG_W'(2)) begin
      ctl_nxt.mode = MODE_SG52;
    end else if (wl_r == CFG_W'(7) && po_r == CFG_W'(2)) begin
      ctl_nxt.mode = MODE_SG72;
    end else if (wl_r == CFG_W'(7) && po_r == CFG_W'(3)) begin
      ctl_nxt.mode = MODE_SG73;
    end else begin
      ctl_nxt.mode = MODE_MA;
    end
    ctl_nxt.rcp = sgs_recip(ctl_nxt.mode, wl_r);

    used_nxt = used_r + USED_W'(launch) - USED_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      wl_r      <= WINDOW_RST;
      po_r      <= ORDER_RST;
      used_r    <= '0;
      job_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW: wl_r <= cfg_data;
          REG_ORDER:  po_r <= cfg_data;
          default:    ;
        endcase
      end
      if (accept) begin
        fill_r <= fill_nxt;
      end
      used_r    <= used_nxt;
      job_vld_r <= launch;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r[0] <= in_beat.sample;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        line_r[i] <= line_r[i-1];
      end
      job_r <= job_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  // The line as the pipeline sees it: entries the line does not have read as zero.
  for (genvar g = 0; g < VIEW_D; g++) begin : g_view
    if (g < MAX_WINDOW) begin : g_have
      assign win[g] = line_r[g];
    end else begin : g_pad
      assign win[g] = '0;
    end
  end

  assign job_vld = job_vld_r;
  assign job     = job_r;
  assign ctl     = ctl_r;

endmodule

### rtl/sgs_mac.sv
module sgs_mac
  import sgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_vld,
  input  job_t              job,
  input  ctl_t              ctl,
  input  smp_t [VIEW_D-1:0] win,
  output logic              res_vld,
  output qent_t             res
);

  localparam int SB     = SGS_SAMPLE_BITS;
  localparam int TW     = SB + 1;
  localparam int NGRP   = (VIEW_D + 3) / 4;
  localparam int GW     = SB + 2;
  localparam int MW     = GW + $clog2(NGRP);
  localparam int PW     = SUM_W + RCP_W + 1;
  localparam int NST    = 4;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SAT_HI = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  logic  vld_p  [NST];
  job_t  job_p  [NST];
  tail_t tail_p [NST];
  ctl_t  ctl_p  [NST];

  // Stage 1: center sample, symmetric pair sums, masked group sums.
  logic signed [TW-1:0]    term_nxt [4];
  logic signed [TW-1:0]    term_r   [4];
  logic signed [GW-1:0]    grp_nxt  [NGRP];
  logic signed [GW-1:0]    grp_r    [NGRP];
  smp_t                    msk      [NGRP*4];
  logic                    h3;

  // Stage 2: coefficient products and the moving-average total.
  logic signed [SUM_W-1:0] prd_nxt  [4];
  logic signed [SUM_W-1:0] prd_r    [4];
  logic signed [MW-1:0]    ma_nxt, ma_r;

  // Stage 3: window sum.  Stage 4: scaled product.
  logic signed [SUM_W-1:0] sacc_nxt, sacc_r;
  logic signed [PW-1:0]    prod_nxt, prod_r;
  logic signed [PW-1:0]    rnd, q;
  smp_t                    sat;

  always_comb begin
    h3 = (ctl.mode == MODE_SG72) || (ctl.mode == MODE_SG73);
    if (h3) begin
      term_nxt[0] = TW'(win[3]);
      term_nxt[1] = TW'(win[2]) + TW'(win[4]);
      term_nxt[2] = TW'(win[1]) + TW'(win[5]);
      term_nxt[3] = TW'(win[0]) + TW'(win[6]);
    end else begin
      term_nxt[0] = TW'(win[2]);
      term_nxt[1] = TW'(win[1]) + TW'(win[3]);
      term_nxt[2] = TW'(win[0]) + TW'(win[4]);
      term_nxt[3] = '0;
    end
    for (int j = 0; j < NGRP*4; j++) begin
      msk[j] = '0;
    end
    for (int j = 0; j < VIEW_D; j++) begin
      if (CFG_W'(j) < ctl.win_len) begin
        msk[j] = win[j];
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = GW'(msk[4*g]) + GW'(msk[4*g+1]) + GW'(msk[4*g+2]) + GW'(msk[4*g+3]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prd_nxt[k] = SUM_W'(sgs_coef(ctl_p[0].mode, 2'(k))) * SUM_W'(term_r[k]);
    end
    ma_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      ma_nxt = ma_nxt + MW'(grp_r[g]);
    end
  end

  always_comb begin
    if (ctl_p[1].mode == MODE_MA) begin
      sacc_nxt = SUM_W'(ma_r);
    end else begin
      sacc_nxt = prd_r[0] + prd_r[1] + prd_r[2] + prd_r[3];
    end
    prod_nxt = PW'(sacc_r) * PW'($signed({1'b0, ctl_p[2].rcp}));
  end

  // Round half up, then clamp to the sample range.
  always_comb begin
    rnd = prod_r + RND_HALF;
    q   = rnd >>> FRAC_BITS;
    if (q > SAT_HI) begin
      sat = SAT_HI[SB-1:0];
    end else if (q < SAT_LO) begin
      sat = SAT_LO[SB-1:0];
    end else begin
      sat = q[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_p[i] <= 1'b0;
      end
      res_vld <= 1'b0;
    end else begin
      vld_p[0] <= job_vld;
      for (int i = 1; i < NST; i++) begin
        vld_p[i] <= vld_p[i-1];
      end
      res_vld <= vld_p[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    job_p[0]  <= job;
    tail_p[0] <= win[TAIL_D-1:0];
    ctl_p[0]  <= ctl;
    for (int i = 1; i < NST; i++) begin
      job_p[i]  <= job_p[i-1];
      tail_p[i] <= tail_p[i-1];
      ctl_p[i]  <= ctl_p[i-1];
    end
    term_r     <= term_nxt;
    grp_r      <= grp_nxt;
    prd_r      <= prd_nxt;
    ma_r       <= ma_nxt;
    sacc_r     <= sacc_nxt;
    prod_r     <= prod_nxt;
    res.job    <= job_p[NST-1];
    res.tail   <= tail_p[NST-1];
    res.smooth <= sat;
  end

endmodule

### rtl/sgs_queue.sv
module sgs_queue
  import sgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output qent_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  qent_t              ent_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;

  // Depth is a power of two, so the pointers simply wrap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_QW'(push) - CNT_QW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = ent_r[rd_ptr_r];
  assign empty = (count_r == '0);

endmodule

### rtl/sgs_back.sv
module sgs_back
  import sgs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  qent_t     head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r;
  out_beat_t        out_beat_r, beat_nxt;
  logic             room, adv, fin;
  logic [IDX_W-1:0] p;

  always_comb begin
    room = !out_valid_r || !out_stall;
    adv  = room && !q_empty;
    p    = head.job.p0 - k_r;
    fin  = (CNT_W'(k_r) + CNT_W'(1) == head.job.cnt);
    pop  = adv && fin;
    k_nxt = fin ? '0 : IDX_W'(k_r + 1'b1);

    beat_nxt.config_error     = head.job.err;
    beat_nxt.last_result      = fin && head.job.last;
    beat_nxt.record_too_short = fin && head.job.short_rec;
    if (head.job.err) begin
      beat_nxt.smoothed = '0;
    end else if (head.job.has_smooth && p == head.job.half) begin
      beat_nxt.smoothed = head.smooth;
    end else begin
      beat_nxt.smoothed = head.tail[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        k_r <= k_nxt;
      end
      if (room) begin
        out_valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

### rtl/savitzky_golay_smoother_unit.sv
// Streaming Savitzky-Golay smoother. Samples of a record enter on the in_ channel at up to
// one beat per clock; results leave on the out_ channel, one beat per clock at most, in
// record order, lagging the input by half a window. Windows of 5 with order 2, and 7 with
// order 2 or 3, use the integer Savitzky-Golay weights; every other valid window is a plain
// moving average. The first and last half-window samples of a record are copied through,
// and the final sample of a record releases the remaining tail of up to eight beats, one
// per clock while out_stall is low. A result passes from its sample through the front's
// job register, the four-stage multiply-and-scale pipeline and its result register, the
// job queue and the output register. A sample that yields a job holds one of eight queue
// credits until the sequencer has moved its last beat into the output register, so
// in_stall rises only while eight jobs are pending, which happens when the output is
// stalled or while a long tail drains. Configuration is written through cfg_ with index 0
// for the window length and 1 for the polynomial order; cfg_ready is always high and writes
// must only happen while no beats are outstanding.
module savitzky_golay_smoother_unit
  import sgs_pkg::*;
#(
  parameter int MAX_WINDOW = SGS_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Front to arithmetic pipeline.
  logic              job_vld;
  job_t              job;
  ctl_t              ctl;
  smp_t [VIEW_D-1:0] win;

  // Pipeline to queue, queue to sequencer.
  logic  res_vld;
  qent_t res;
  qent_t head;
  logic  q_empty;
  logic  pop;

  // The front keeps the delay line, the record fill count and the registers, and decides
  // for every sample how many beats it releases. It launches a job in the cycle after the
  // sample is taken, while the delay line still holds exactly that sample's window.
  sgs_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pop      (pop),
    .job_vld  (job_vld),
    .job      (job),
    .ctl      (ctl),
    .win      (win)
  );

  // The pipeline never stalls: credits in the front guarantee queue space for every job
  // in flight. It forms the weighted window sum, scales it by the reciprocal of the
  // denominator, rounds and saturates, and snapshots the tail samples alongside.
  sgs_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_vld(job_vld),
    .job    (job),
    .ctl    (ctl),
    .win    (win),
    .res_vld(res_vld),
    .res    (res)
  );

  sgs_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_vld),
    .wdata(res),
    .pop  (pop),
    .rdata(head),
    .empty(q_empty)
  );

  // The sequencer walks each job beat by beat into the output register.
  sgs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

### rtl/sgs_checker.sv
module sgs_checker
  import sgs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed or dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.config_error |->
      out_beat.smoothed == '0 && !out_beat.record_too_short)
    else $error("configuration error beat carries data or a short-record flag");

  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.record_too_short |-> out_beat.last_result)
    else $error("short-record flag on a beat that does not end the record");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle and ready after reset");

endmodule

bind savitzky_golay_smoother_unit sgs_checker u_sgs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_beat (out_beat)
);
